// ===== rtl/tspe_pkg.sv =====
// ----------------------------------------------------------------------------
// tspe_pkg
// Shared types and constants for the transport stream PID payload extractor.
// ----------------------------------------------------------------------------
package tspe_pkg;

    localparam int PACKET_BYTES_DEF = 188;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int POS_W      = 8;
    localparam int START_W    = 9;
    localparam int PID_W      = 13;
    localparam int BYTE_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BYTE_W-1:0]  SYNC_BYTE    = 8'h47;
    localparam logic [START_W-1:0] HEADER_BYTES = 9'd4;

    // byte offsets of the header fields
    localparam logic [POS_W-1:0] POS_SYNC      = 8'd0;
    localparam logic [POS_W-1:0] POS_PID_HI    = 8'd1;
    localparam logic [POS_W-1:0] POS_PID_LO    = 8'd2;
    localparam logic [POS_W-1:0] POS_FLAGS     = 8'd3;
    localparam logic [POS_W-1:0] POS_ADAPT_LEN = 8'd4;

    // adaptation field control values from which a length byte is present
    localparam logic [1:0] AFC_ADAPT_MIN = 2'd2;

    // register index (byte address bit 2)
    localparam logic REG_TARGET_PID = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              packet_end;
        logic              sync_error;
    } tspe_item_t;

endpackage

// ===== rtl/tspe_channels.sv =====
// ----------------------------------------------------------------------------
// tspe_channels
// Valid/ready channels for stream bytes in and result words out.
// ----------------------------------------------------------------------------
interface tspe_byte_if
    import tspe_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tspe_result_if
    import tspe_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              packet_end;
    logic              sync_error;

    modport source (output valid, output payload_byte, output packet_end,
                    output sync_error, input ready);
    modport sink   (input valid, input payload_byte, input packet_end,
                    input sync_error, output ready);
endinterface

// ===== rtl/tspe_regs.sv =====
// ----------------------------------------------------------------------------
// tspe_regs
// APB-style register bank holding the target PID.
// ----------------------------------------------------------------------------
module tspe_regs
    import tspe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [PID_W-1:0]      target_pid
);

    logic [PID_W-1:0] target_pid_reg;
    logic [PID_W-1:0] target_pid_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        target_pid_next = target_pid_reg;
        if (wr_en && (paddr[2] == REG_TARGET_PID))
        begin
            target_pid_next = pwdata[PID_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_pid_reg <= '0;
        end
        else
        begin
            target_pid_reg <= target_pid_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TARGET_PID)
        begin
            prdata = {{(CFG_DATA_W-PID_W){1'b0}}, target_pid_reg};
        end
    end

    assign target_pid = target_pid_reg;

endmodule

// ===== rtl/tspe_front.sv =====
// ----------------------------------------------------------------------------
// tspe_front
// Tracks the packet offset, parses the header and picks out payload words.
// ----------------------------------------------------------------------------
module tspe_front
    import tspe_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    tspe_byte_if.sink        stream,
    input  logic [PID_W-1:0] target_pid,
    input  logic             queue_full,
    output logic             push,
    output tspe_item_t       push_item
);

    localparam logic [POS_W-1:0] POS_BYTES_LAST = POS_W'(PACKET_BYTES - 1);

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [PID_W-1:0]   pid_reg;
    logic [PID_W-1:0]   pid_next;
    logic               match_reg;
    logic               match_next;
    logic [1:0]         afc_reg;
    logic [1:0]         afc_next;
    logic [START_W-1:0] start_reg;
    logic [START_W-1:0] start_next;
    logic               halted_reg;
    logic               halted_next;
    logic               accept;
    logic [BYTE_W-1:0]  b;

    // once halted every word is swallowed
    assign stream.ready = halted_reg || !queue_full;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.stream_byte;

    always_comb
    begin
        pos_next    = pos_reg;
        pid_next    = pid_reg;
        match_next  = match_reg;
        afc_next    = afc_reg;
        start_next  = start_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        push_item   = '{payload_byte: b, packet_end: 1'b0, sync_error: 1'b0};

        if (accept && !halted_reg)
        begin
            if (pos_reg == POS_BYTES_LAST)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end

            case (pos_reg)
                POS_SYNC:
                begin
                    if (b != SYNC_BYTE)
                    begin
                        halted_next = 1'b1;
                        pos_next    = pos_reg;
                        push        = 1'b1;
                        push_item   = '{payload_byte: '0, packet_end: 1'b0,
                                        sync_error: 1'b1};
                    end
                end
                POS_PID_HI:
                begin
                    pid_next = {b[4:0], 8'h00};
                end
                POS_PID_LO:
                begin
                    pid_next   = {pid_reg[PID_W-1:8], b};
                    match_next = ({pid_reg[PID_W-1:8], b} == target_pid);
                end
                POS_FLAGS:
                begin
                    afc_next   = b[5:4];
                    start_next = HEADER_BYTES;
                end
                default:
                begin
                    if ((pos_reg == POS_ADAPT_LEN) && (afc_reg >= AFC_ADAPT_MIN))
                    begin
                        start_next = {1'b0, b} + HEADER_BYTES + 9'd1;
                    end
                    if (match_reg && ({1'b0, pos_reg} >= start_next))
                    begin
                        push      = 1'b1;
                        push_item = '{payload_byte: b,
                                      packet_end: (pos_reg == POS_BYTES_LAST),
                                      sync_error: 1'b0};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            pid_reg    <= '0;
            match_reg  <= 1'b0;
            afc_reg    <= '0;
            start_reg  <= HEADER_BYTES;
            halted_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            pid_reg    <= pid_next;
            match_reg  <= match_next;
            afc_reg    <= afc_next;
            start_reg  <= start_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== rtl/tspe_queue.sv =====
// ----------------------------------------------------------------------------
// tspe_queue
// Short FIFO of result words between the parser and the output stage.
// ----------------------------------------------------------------------------
module tspe_queue
    import tspe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tspe_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output tspe_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tspe_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/tspe_back.sv =====
// ----------------------------------------------------------------------------
// tspe_back
// Output register stage driving the result channel from the queue head.
// ----------------------------------------------------------------------------
module tspe_back
    import tspe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  tspe_item_t head_item,
    output logic       pop,
    tspe_result_if.source result
);

    logic       valid_reg;
    logic       valid_next;
    tspe_item_t item_reg;

    // refill whenever the register is empty or being drained
    assign pop = head_valid && (!valid_reg || result.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
        end
    end

    assign result.valid        = valid_reg;
    assign result.payload_byte = item_reg.payload_byte;
    assign result.packet_end   = item_reg.packet_end;
    assign result.sync_error   = item_reg.sync_error;

endmodule

// ===== rtl/ts_pid_payload_extractor.sv =====
// ----------------------------------------------------------------------------
// ts_pid_payload_extractor
// Transport stream PID filter passing the payload words of one PID.
// ----------------------------------------------------------------------------
// Takes one stream word per cycle and returns at most one result word per
// input word, so it sustains one word per cycle whenever the result side
// keeps up. A payload or sync error word goes from the header parser into the
// result queue and then into the output register before it appears on the
// result side. The queue of QUEUE_DEPTH words absorbs stalls on the result
// side; the input stalls only once it is full. After a sync error the input
// is drained and ignored until reset. target_pid sits at byte address 0 and
// is sampled when the PID's low byte arrives, so a write after that byte
// applies from the next packet on. No initialisation pass follows reset.
// ----------------------------------------------------------------------------
module ts_pid_payload_extractor
    import tspe_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tspe_byte_if.sink             stream,
    tspe_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [PID_W-1:0] target_pid;
    logic             push;
    tspe_item_t       push_item;
    logic             queue_full;
    logic             head_valid;
    tspe_item_t       head_item;
    logic             pop;

    tspe_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .target_pid (target_pid)
    );

    tspe_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .target_pid (target_pid),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    tspe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (head_valid),
        .head_item (head_item)
    );

    tspe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== tb/ts_pid_payload_extractor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ts_pid_payload_extractor_tb
// Drives whole transport stream packets into the extractor and checks every
// result word against a cycle-free model of the PID filter, covering target
// register writes, all adaptation field control values, adaptation lengths
// up to and past the packet end, result-side stalls and the final sync error.
// ----------------------------------------------------------------------------
module ts_pid_payload_extractor_tb;
    import tspe_pkg::*;

    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          HOLD_CYCLES  = 100;
    localparam int          RANDOM_BYTES = 188;
    localparam int          MAX_REPORTS  = 40;
    localparam logic [7:0]  LAST_POS     = 8'(PACKET_BYTES_DEF - 1);

    // adaptation field control codes
    localparam logic [1:0] AFC_RESERVED = 2'd0;
    localparam logic [1:0] AFC_PAYLOAD  = 2'd1;
    localparam logic [1:0] AFC_ADAPT    = 2'd2;
    localparam logic [1:0] AFC_BOTH     = 2'd3;

    // register byte addresses
    localparam logic [CFG_ADDR_W-1:0] ADDR_TARGET = {REG_TARGET_PID, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE  = {~REG_TARGET_PID, 2'b00};

    typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_CYCLIC} sink_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tspe_byte_if   stream_if ();
    tspe_result_if result_if ();

    ts_pid_payload_extractor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // filter model state
    logic [PID_W-1:0]   tgt_pid;
    logic [POS_W-1:0]   m_pos;
    logic [PID_W-1:0]   m_pid;
    logic               m_match;
    logic [1:0]         m_afc;
    logic [START_W-1:0] m_start;
    logic               m_halt;

    tspe_item_t expected_words[$];

    logic [7:0] pkt_buf [PACKET_BYTES_DEF];

    int         errors       = 0;
    int         bytes_sent   = 0;
    int         payload_seen = 0;
    int         ends_seen    = 0;
    int         syncs_seen   = 0;
    int         burst_left   = 0;
    logic       src_steady   = 1'b1;
    logic       hold_req     = 1'b0;
    sink_mode_t sink_mode    = SINK_OPEN;

    // one stream word through the filter model
    task automatic extract_byte(input logic [7:0] b);
        tspe_item_t w;
        w = '0;
        if (!m_halt)
        begin
            if (m_pos == POS_SYNC)
            begin
                if (b != SYNC_BYTE)
                begin
                    m_halt       = 1'b1;
                    w.sync_error = 1'b1;
                    expected_words.push_back(w);
                end
            end
            else if (m_pos == POS_PID_HI)
                m_pid = {b[4:0], 8'h00};
            else if (m_pos == POS_PID_LO)
            begin
                m_pid[7:0] = b;
                m_match    = (m_pid == tgt_pid);
            end
            else if (m_pos == POS_FLAGS)
            begin
                m_afc   = b[5:4];
                m_start = HEADER_BYTES;
            end
            else
            begin
                // length byte sits below the payload start, so never emitted
                if (m_pos == POS_ADAPT_LEN && m_afc >= AFC_ADAPT_MIN)
                    m_start = {1'b0, b} + HEADER_BYTES + 9'd1;
                if (m_match && {1'b0, m_pos} >= m_start)
                begin
                    w.payload_byte = b;
                    w.packet_end   = (m_pos == LAST_POS);
                    expected_words.push_back(w);
                end
            end
            if (!m_halt)
                m_pos = (m_pos == LAST_POS) ? '0 : m_pos + 8'd1;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        int gap;
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= b;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        extract_byte(b);
        bytes_sent++;
        if (!src_steady)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 12);
                stream_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 40);
            end
            else
                burst_left--;
        end
    endtask

    task automatic build_packet(input logic [PID_W-1:0] pid, input logic [1:0] afc,
                                input logic [7:0] alen);
        for (int i = 0; i < PACKET_BYTES_DEF; i++)
            pkt_buf[i] = 8'($urandom);
        pkt_buf[0] = SYNC_BYTE;
        pkt_buf[1] = {pkt_buf[1][7:5], pid[12:8]};
        pkt_buf[2] = pid[7:0];
        pkt_buf[3] = {pkt_buf[3][7:6], afc, pkt_buf[3][3:0]};
        if (afc >= AFC_ADAPT_MIN)
            pkt_buf[4] = alen;
    endtask

    task automatic send_range(input int first, input int last);
        for (int i = first; i <= last; i++)
            push_byte(pkt_buf[i]);
    endtask

    task automatic send_packet(input logic [PID_W-1:0] pid, input logic [1:0] afc,
                               input logic [7:0] alen);
        build_packet(pid, afc, alen);
        send_range(0, PACKET_BYTES_DEF - 1);
    endtask

    // stop offering, let all results out and give the pipeline time to settle
    task automatic wait_idle();
        stream_if.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TARGET)
            tgt_pid = data[PID_W-1:0];
        @(posedge clk);
    endtask

    task automatic reg_read_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TARGET;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(tgt_pid))
        begin
            errors++;
            $display("%0t: target_pid readback expected %08h got %08h",
                     $time, 32'(tgt_pid), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [PID_W-1:0] pick_pid();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return PID_W'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_target();
        reg_read_check();
        // payload only, with extreme payload values and the sync value inside
        build_packet('0, AFC_PAYLOAD, 8'd0);
        pkt_buf[4]   = 8'h00;
        pkt_buf[5]   = 8'hff;
        pkt_buf[6]   = SYNC_BYTE;
        pkt_buf[187] = 8'hff;
        send_range(0, PACKET_BYTES_DEF - 1);
    endtask

    task automatic test_register_port();
        wait_idle();
        reg_write(ADDR_TARGET, 32'hffff_ffff);
        reg_read_check();
        reg_write(ADDR_SPARE, 32'h0000_0123);
        reg_read_check();
        // top bits must be dropped
        wait_idle();
        reg_write(ADDR_TARGET, 32'hffff_e000 | 32'h0abc);
        reg_read_check();
    endtask

    task automatic test_adaptation_lengths();
        send_packet(tgt_pid, AFC_BOTH, 8'd182);   // only the last word
        send_packet(tgt_pid, AFC_ADAPT, 8'd183);  // start lands past the end
    endtask

    task automatic test_pid_filter();
        send_packet(tgt_pid ^ 13'h1000, AFC_PAYLOAD, 8'd0);
    endtask

    task automatic test_pid_latch();
        logic [PID_W-1:0] other;
        other = tgt_pid ^ 13'h0555;
        // write lands before the low pid byte: this packet already uses it
        build_packet(other, AFC_PAYLOAD, 8'd0);
        send_range(0, 1);
        wait_idle();
        reg_write(ADDR_TARGET, 32'(other));
        send_range(2, PACKET_BYTES_DEF - 1);
        // write lands after the compare: only the next packet sees it
        build_packet(other, AFC_ADAPT, 8'd20);
        send_range(0, 3);
        wait_idle();
        reg_write(ADDR_TARGET, 32'(other ^ 13'h1fff));
        send_range(4, PACKET_BYTES_DEF - 1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        src_steady = 1'b1;
        sink_mode  = SINK_OPEN;
        hold_req   = 1'b1;
        // reserved control value behaves as payload only
        send_packet(tgt_pid, AFC_RESERVED, 8'd0);
    endtask

    task automatic test_random_stream();
        int         stop_at;
        logic [1:0] afc;
        logic [7:0] alen;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wait_idle();
                reg_write(ADDR_TARGET, ($urandom() & 32'hffff_e000) | 32'(pick_pid()));
                if ($urandom_range(0, 1) == 0)
                    reg_read_check();
            end
            src_steady = ($urandom_range(0, 3) == 0);
            sink_mode  = sink_mode_t'($urandom_range(0, 2));
            afc        = 2'($urandom_range(0, 3));
            alen       = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 182))
                                                     : 8'($urandom_range(0, 16));
            case ($urandom_range(0, 9))
                7:       send_packet(tgt_pid ^ PID_W'($urandom_range(1, 8191)), afc, alen);
                8:       send_packet(tgt_pid, AFC_ADAPT | 2'($urandom_range(0, 1)),
                                     8'($urandom_range(183, 255)));
                9:       send_packet(pick_pid(), afc, alen);
                default: send_packet(tgt_pid, afc, alen);
            endcase
        end
    endtask

    task automatic test_sync_error();
        wait_idle();
        src_steady = 1'b0;
        sink_mode  = SINK_CHOPPY;
        build_packet(tgt_pid, AFC_PAYLOAD, 8'd0);
        do
            pkt_buf[0] = 8'($urandom_range(0, 255));
        while (pkt_buf[0] == SYNC_BYTE);
        pkt_buf[40] = SYNC_BYTE;
        send_range(0, 31);
        // halted: register still writable, stream swallowed without results
        wait_idle();
        reg_write(ADDR_TARGET, 32'h0000_1234);
        reg_read_check();
        send_range(32, 63);
    endtask

    // ------------------------------------------------------------- processes

    // result side: own stall pattern plus a long hold-off on request
    initial
    begin : result_sink
        int phase;
        phase = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (hold_req)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                result_if.ready <= 1'b1;
            end
            else
            begin
                case (sink_mode)
                    SINK_OPEN:   result_if.ready <= 1'b1;
                    SINK_CHOPPY: result_if.ready <= ($urandom_range(0, 99) < 60);
                    default:     result_if.ready <= ((phase % 7) >= 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        tspe_item_t got;
        tspe_item_t want;
        if (result_if.valid && result_if.ready)
        begin
            got.payload_byte = result_if.payload_byte;
            got.packet_end   = result_if.packet_end;
            got.sync_error   = result_if.sync_error;
            payload_seen += !got.sync_error;
            ends_seen    += got.packet_end;
            syncs_seen   += got.sync_error;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word: expected none, got %02h end %0b sync %0b",
                             $time, got.payload_byte, got.packet_end, got.sync_error);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.payload_byte !== want.payload_byte)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: payload_byte expected %02h got %02h",
                                 $time, want.payload_byte, got.payload_byte);
                end
                if (got.packet_end !== want.packet_end)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: packet_end expected %0b got %0b",
                                 $time, want.packet_end, got.packet_end);
                end
                if (got.sync_error !== want.sync_error)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: sync_error expected %0b got %0b",
                                 $time, want.sync_error, got.sync_error);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("ts_pid_payload_extractor test failed");
        $finish;
    end

    initial
    begin : main_flow
        rst_n                 <= 1'b0;
        stream_if.valid       <= 1'b0;
        stream_if.stream_byte <= '0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        tgt_pid = '0;
        m_pos   = '0;
        m_pid   = '0;
        m_match = 1'b0;
        m_afc   = '0;
        m_start = HEADER_BYTES;
        m_halt  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_target();
        src_steady = 1'b0;
        sink_mode  = SINK_CYCLIC;
        test_register_port();
        sink_mode  = SINK_CHOPPY;
        test_adaptation_lengths();
        test_pid_filter();
        test_pid_latch();
        test_backpressure();
        test_random_stream();
        test_sync_error();
        wait_idle();

        $display("covered %0d stream words (about %0d packets): %0d payload words,",
                 bytes_sent, bytes_sent / PACKET_BYTES_DEF, payload_seen);
        $display("%0d packet ends, %0d sync error, %0d mismatches", ends_seen, syncs_seen,
                 errors);
        if (errors == 0 && expected_words.size() == 0)
            $display("ts_pid_payload_extractor test passed");
        else
            $display("ts_pid_payload_extractor test failed");
        $finish;
    end

endmodule
